// ===== src/tmvf_pkg.sv =====
// Package: register indexes, type and predicate codes, type table lookups.
package tmvf_pkg;

    typedef enum logic [2:0] {
        PRED_LT      = 3'd0,
        PRED_GT      = 3'd1,
        PRED_LE      = 3'd2,
        PRED_GE      = 3'd3,
        PRED_EQ      = 3'd4,
        PRED_NE      = 3'd5,
        PRED_ONE_BIT = 3'd6,
        PRED_ALL     = 3'd7
    } pred_t;

    typedef enum logic [1:0] {
        KIND_UNS = 2'd0,
        KIND_SGN = 2'd1,
        KIND_FLT = 2'd2,
        KIND_RAW = 2'd3
    } kind_t;

    localparam logic [2:0] REG_SEARCH_TYPE = 3'd0;
    localparam logic [2:0] REG_PREDICATE   = 3'd1;
    localparam logic [2:0] REG_REFERENCE   = 3'd2;
    localparam logic [2:0] REG_WITH_PREV   = 3'd3;
    localparam logic [2:0] REG_RAW_BYTES   = 3'd4;

    localparam logic [4:0] TYPE_RAW = 5'd18;

    typedef struct packed {
        logic       invalid;
        kind_t      kind;
        logic [3:0] nbytes;
        logic       rev;
    } type_info_t;

    typedef struct packed {
        logic  [4:0] search_type;
        pred_t       predicate;
        logic [63:0] reference_value;
        logic        compare_with_previous;
        logic  [3:0] raw_bytes;
    } cfg_t;

    function automatic type_info_t type_info(input logic [4:0] t);
        type_info_t r;
        r.invalid = 1'b0;
        r.rev     = 1'b0;
        r.kind    = KIND_UNS;
        r.nbytes  = 4'd8;
        unique case (t)
            5'd0:  begin r.nbytes = 4'd1; end
            5'd1:  begin r.nbytes = 4'd2; end
            5'd2:  begin r.nbytes = 4'd2; r.rev = 1'b1; end
            5'd3:  begin r.nbytes = 4'd4; end
            5'd4:  begin r.nbytes = 4'd4; r.rev = 1'b1; end
            5'd5:  begin r.nbytes = 4'd8; end
            5'd6:  begin r.nbytes = 4'd8; r.rev = 1'b1; end
            5'd7:  begin r.nbytes = 4'd1; r.kind = KIND_SGN; end
            5'd8:  begin r.nbytes = 4'd2; r.kind = KIND_SGN; end
            5'd9:  begin r.nbytes = 4'd2; r.kind = KIND_SGN; r.rev = 1'b1; end
            5'd10: begin r.nbytes = 4'd4; r.kind = KIND_SGN; end
            5'd11: begin r.nbytes = 4'd4; r.kind = KIND_SGN; r.rev = 1'b1; end
            5'd12: begin r.nbytes = 4'd8; r.kind = KIND_SGN; end
            5'd13: begin r.nbytes = 4'd8; r.kind = KIND_SGN; r.rev = 1'b1; end
            5'd14: begin r.nbytes = 4'd4; r.kind = KIND_FLT; end
            5'd15: begin r.nbytes = 4'd4; r.kind = KIND_FLT; r.rev = 1'b1; end
            5'd16: begin r.nbytes = 4'd8; r.kind = KIND_FLT; end
            5'd17: begin r.nbytes = 4'd8; r.kind = KIND_FLT; r.rev = 1'b1; end
            5'd18: begin r.nbytes = 4'd8; r.kind = KIND_RAW; end
            default: begin r.invalid = 1'b1; end
        endcase
        return r;
    endfunction

endpackage

// ===== src/tmvf_pipe.sv =====
// Module: three-stage compare pipeline (typing, compare, predicate).
module tmvf_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmvf_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          in_address,
    input  logic [63:0]          in_current,
    input  logic [63:0]          in_previous,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_match,
    output logic [63:0]          out_address,
    output logic                 out_last,
    output logic                 out_bad
);

    tmvf_pkg::type_info_t ti;
    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1 registers, plus the stage 2 address and last registers
    logic [63:0] a1_reg, b1_reg, addr1_reg, addr2_reg;
    logic        last1_reg, last2_reg;

    // stage 2 registers
    logic        lt2_reg, gt2_reg, eq2_reg, one2_reg, nan2_reg;
    logic        fz2_reg;

    logic [63:0] a_next, b_next, cmp_b;

    assign ti = tmvf_pkg::type_info(cfg.search_type);

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    // typing: mask and byte-reverse; the sign flip into unsigned order is done in stage 2
    function automatic logic [63:0] shape(input logic [63:0] w, input logic [3:0] n,
                                          input logic rev);
        logic [63:0] r;
        r = '0;
        unique case (n)
            4'd1: r = {56'd0, w[7:0]};
            4'd2: r = rev ? {48'd0, w[7:0], w[15:8]} : {48'd0, w[15:0]};
            4'd4: r = rev ? {32'd0, w[7:0], w[15:8], w[23:16], w[31:24]}
                          : {32'd0, w[31:0]};
            default: r = rev ? {w[7:0], w[15:8], w[23:16], w[31:24],
                                w[39:32], w[47:40], w[55:48], w[63:56]} : w;
        endcase
        return r;
    endfunction

    always_comb
    begin
        cmp_b  = cfg.compare_with_previous ? in_previous : cfg.reference_value;
        a_next = in_current;
        b_next = cmp_b;
        if (ti.kind != tmvf_pkg::KIND_RAW)
        begin
            a_next = shape(in_current, ti.nbytes, ti.rev);
            b_next = cfg.compare_with_previous ? shape(in_previous, ti.nbytes, ti.rev)
                                               : shape(cfg.reference_value, ti.nbytes,
                                                       1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            a1_reg    <= a_next;
            b1_reg    <= b_next;
            addr1_reg <= in_address;
            last1_reg <= in_last;
        end
    end

    // stage 2: compare in the order the type wants
    logic [63:0] x, y, d;
    logic        lt_c, gt_c, eq_c, one_c, nan_c, fz_c;
    logic [3:0]  nr;
    logic [3:0]  ones_cnt;

    always_comb
    begin
        x = a1_reg;
        y = b1_reg;
        nan_c = 1'b0;
        fz_c  = 1'b0;
        nr = (cfg.raw_bytes > 4'd8) ? 4'd8 : cfg.raw_bytes;
        ones_cnt = '0;
        one_c = 1'b0;
        d = a1_reg ^ b1_reg;
        unique case (ti.kind)
            tmvf_pkg::KIND_SGN:
            begin
                unique case (ti.nbytes)
                    4'd1:    begin x[7]  = ~x[7];  y[7]  = ~y[7];  end
                    4'd2:    begin x[15] = ~x[15]; y[15] = ~y[15]; end
                    4'd4:    begin x[31] = ~x[31]; y[31] = ~y[31]; end
                    default: begin x[63] = ~x[63]; y[63] = ~y[63]; end
                endcase
            end
            tmvf_pkg::KIND_FLT:
            begin
                // sign-magnitude to monotonic unsigned key
                if (ti.nbytes == 4'd4)
                begin
                    nan_c = (&a1_reg[30:23] && |a1_reg[22:0]) ||
                            (&b1_reg[30:23] && |b1_reg[22:0]);
                    fz_c  = (a1_reg[30:0] == '0) && (b1_reg[30:0] == '0);
                    x = {32'd0, a1_reg[31] ? ~a1_reg[31:0] : {1'b1, a1_reg[30:0]}};
                    y = {32'd0, b1_reg[31] ? ~b1_reg[31:0] : {1'b1, b1_reg[30:0]}};
                end
                else
                begin
                    nan_c = (&a1_reg[62:52] && |a1_reg[51:0]) ||
                            (&b1_reg[62:52] && |b1_reg[51:0]);
                    fz_c  = (a1_reg[62:0] == '0) && (b1_reg[62:0] == '0);
                    x = a1_reg[63] ? ~a1_reg : {1'b1, a1_reg[62:0]};
                    y = b1_reg[63] ? ~b1_reg : {1'b1, b1_reg[62:0]};
                end
            end
            tmvf_pkg::KIND_RAW:
            begin
                // lexicographic: byte 0 most significant, unused bytes zeroed
                for (int i = 0; i < 8; i++)
                begin
                    if (4'(i) < nr)
                    begin
                        x[63-8*i -: 8] = a1_reg[8*i +: 8];
                        y[63-8*i -: 8] = b1_reg[8*i +: 8];
                        if ($countones(d[8*i +: 8]) == 1)
                            ones_cnt = ones_cnt + 4'd1;
                    end
                    else
                    begin
                        x[63-8*i -: 8] = 8'd0;
                        y[63-8*i -: 8] = 8'd0;
                    end
                end
            end
            default: ;
        endcase
        lt_c = x < y;
        gt_c = x > y;
        eq_c = x == y;
        if (ti.kind == tmvf_pkg::KIND_RAW)
            one_c = ones_cnt == 4'd1;
        else
            one_c = (d != '0) && ((d & (d - 64'd1)) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            lt2_reg   <= lt_c;
            gt2_reg   <= gt_c;
            eq2_reg   <= eq_c;
            one2_reg  <= one_c;
            nan2_reg  <= nan_c;
            fz2_reg   <= fz_c;
            addr2_reg <= addr1_reg;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: apply predicate
    logic m_c, bad_c, lt_f, gt_f, eq_f;

    always_comb
    begin
        lt_f = lt2_reg && !fz2_reg;
        gt_f = gt2_reg && !fz2_reg;
        eq_f = eq2_reg || fz2_reg;
        bad_c = ti.invalid ||
                (ti.kind == tmvf_pkg::KIND_FLT && cfg.predicate == tmvf_pkg::PRED_ONE_BIT);
        m_c = 1'b0;
        unique case (cfg.predicate)
            tmvf_pkg::PRED_LT:      m_c = lt_f;
            tmvf_pkg::PRED_GT:      m_c = gt_f;
            tmvf_pkg::PRED_LE:      m_c = !gt_f;
            tmvf_pkg::PRED_GE:      m_c = !lt_f;
            tmvf_pkg::PRED_EQ:      m_c = eq_f;
            tmvf_pkg::PRED_NE:      m_c = !eq_f;
            tmvf_pkg::PRED_ONE_BIT: m_c = one2_reg;
            default:                m_c = 1'b1;
        endcase
        if (nan2_reg && ti.kind == tmvf_pkg::KIND_FLT &&
            cfg.predicate != tmvf_pkg::PRED_ALL)
            m_c = (cfg.predicate == tmvf_pkg::PRED_NE);
        if (bad_c)
            m_c = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_match   <= m_c;
            out_bad     <= bad_c;
            out_address <= addr2_reg;
            out_last    <= last2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_ready |=> v3_reg && $stable(out_address))
        else $error("result dropped under stall");
    a_bad_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && out_bad |-> !out_match)
        else $error("match with bad combination");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv2 |=> v2_reg)
        else $error("item lost between stages");

endmodule

// ===== src/typed_memory_value_filter.sv =====
// Top level: typed memory value filter with configuration registers.
// Pipeline: the result passes three register stages (typing, compare,
// predicate), the first loading at the accepting edge.
// Throughput: one item per cycle; the pipeline stalls only when the result is not taken.
// Reset: configuration returns to type u8, predicate always true, reference 0,
// no previous compare, eight raw bytes; the pipeline empties.
module typed_memory_value_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] address,
    input  logic [63:0] current_word,
    input  logic [63:0] previous_word,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        match,
    output logic [63:0] match_address,
    output logic        end_of_scan,
    output logic        bad_combination
);

    tmvf_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_type           <= 5'd0;
            cfg_reg.predicate             <= tmvf_pkg::PRED_ALL;
            cfg_reg.reference_value       <= 64'd0;
            cfg_reg.compare_with_previous <= 1'b0;
            cfg_reg.raw_bytes             <= 4'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tmvf_pkg::REG_SEARCH_TYPE: cfg_reg.search_type <= cfg_data[4:0];
                tmvf_pkg::REG_PREDICATE:   cfg_reg.predicate <= tmvf_pkg::pred_t'(cfg_data[2:0]);
                tmvf_pkg::REG_REFERENCE:   cfg_reg.reference_value <= cfg_data;
                tmvf_pkg::REG_WITH_PREV:   cfg_reg.compare_with_previous <= cfg_data[0];
                tmvf_pkg::REG_RAW_BYTES:   cfg_reg.raw_bytes <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tmvf_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_address  (address),
        .in_current  (current_word),
        .in_previous (previous_word),
        .in_last     (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_match   (match),
        .out_address (match_address),
        .out_last    (end_of_scan),
        .out_bad     (bad_combination)
    );

endmodule
